@@ design/eim_pkg.sv @@
package eim_pkg;

   // bus phases of the slave state machine
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START    = 4'd1,
      PH_RX_CMD   = 4'd2,
      PH_ACK_CMD  = 4'd3,
      PH_RX_ADDR  = 4'd4,
      PH_ACK_ADDR = 4'd5,
      PH_RX_DATA  = 4'd6,
      PH_ACK_WR   = 4'd7,
      PH_WRPEND   = 4'd8,
      PH_TX_DATA  = 4'd9,
      PH_ACK_RD   = 4'd10
   } phase_type;

   localparam logic [7:0]  CMD_MASK         = 8'hF0;
   localparam logic [7:0]  CMD_DEVICE_ID    = 8'hA0;
   localparam logic [7:0]  CMD_READ_BIT     = 8'h01;
   localparam logic [3:0]  BYTE_BITS        = 4'd8;
   localparam logic [15:0] WRITE_TIME_RESET = 16'd4000;

endpackage

@@ design/eim_ram.sv @@
module eim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/i2c_eeprom_slave.sv @@
// i2c serial eeprom slave, 24xx style
// req channel: one transaction per clock tick of the bus, carrying the sampled
//   scl and sda line levels; rsp channel: one transaction per req transaction,
//   carrying the sda drive (1 releases, 0 pulls low) and the busy flag
// csr port: csr_wr_en writes csr_wr_data into write_time, the number of ticks
//   the device stays busy after a committed write (0 acts as 1)
// throughput: one req transaction per cycle while rsp does not stall; the byte store is a
//   single-port-write ram whose read port prefetches the current word address
//   every cycle, so a read command or master ack finds its byte ready
// latency: the response for a req transaction is shown the cycle after accept
// when rsp stalls, the output register holds the response and req_tready
//   drops until it is taken; nothing is lost or repeated
// reset (synchronous, active high): bus idle, sda released, not busy,
//   write_time 4000; the byte store reads as zero at once through one valid
//   bit per entry, so no clearing pass is needed
module i2c_eeprom_slave
   import eim_pkg::*;
#(
   parameter int MEM_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] scl_level, [1] sda_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [0] sda_release, [1] busy_res
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data   // write_time
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [11:0] DEPTH_W = 12'(MEM_DEPTH);
   localparam logic [AW:0] DEPTH_A = (AW + 1)'(MEM_DEPTH);

   // architectural state
   phase_type      phase_ff, phase_in;
   logic [7:0]     shift_ff, shift_in;
   logic [3:0]     bitcnt_ff, bitcnt_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           drive_ff, drive_in;
   logic           busy_ff, busy_in;
   logic [15:0]    ticks_ff, ticks_in;
   logic           last_scl_ff, last_scl_in;
   logic           last_sda_ff, last_sda_in;
   logic [15:0]    write_time_ff;

   // byte store bookkeeping
   logic [MEM_DEPTH-1:0] valid_ff;
   logic                 rd_valid_ff;
   logic                 fwd_ff;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           ram_q;
   logic [7:0]           mem_byte;
   logic                 ram_we;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic       accept;
   logic       scl, sda;
   logic       scl_fall;
   logic       bus_cond;
   logic       is_stop, is_start;
   logic       busy_dec;
   logic [15:0] ticks_dec;
   logic [7:0] shift_rx;
   logic [3:0] bitcnt_rx;
   logic       byte_done;
   logic [11:0] addr_mod;
   logic [AW-1:0] addr_rx;
   logic [AW:0] addr_plus;
   logic [AW-1:0] addr_next;
   logic [2:0] tx_bit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign scl        = req_tdata[0];
   assign sda        = req_tdata[1];

   // falling scl steps the phase machine; sda change with scl held high is a
   // start (falling) or a stop (rising)
   assign scl_fall = last_scl_ff && !scl;
   assign bus_cond = last_scl_ff && scl && (sda != last_sda_ff);
   assign is_stop  = accept && bus_cond && sda;
   assign is_start = accept && bus_cond && !sda && !busy_dec;

   // the byte at the current address; a write in the previous cycle is
   // forwarded, an entry never written reads as zero
   assign mem_byte = fwd_ff ? fwd_data_ff : (rd_valid_ff ? ram_q : 8'h00);

   // receive shifter
   assign shift_rx  = {shift_ff[6:0], sda};
   assign bitcnt_rx = bitcnt_ff + 4'd1;
   assign byte_done = (bitcnt_rx == BYTE_BITS);

   // transmit bit index after the countdown
   assign tx_bit = bitcnt_ff[2:0] - 3'd1;

   // received address folded into the store depth by restoring subtraction
   always_comb begin
      addr_mod = {4'd0, shift_rx};
      for (int k = 3; k >= 0; k--) begin
         if (addr_mod >= (DEPTH_W << k)) begin
            addr_mod = addr_mod - (DEPTH_W << k);
         end
      end
   end
   assign addr_rx = addr_mod[AW-1:0];

   // address increment with wrap at the store depth
   assign addr_plus = {1'b0, addr_ff} + {{AW{1'b0}}, 1'b1};
   assign addr_next = (addr_plus == DEPTH_A) ? '0 : addr_plus[AW-1:0];

   // busy countdown happens before the bus is looked at
   always_comb begin
      busy_dec  = busy_ff;
      ticks_dec = ticks_ff;
      if (busy_ff) begin
         if (ticks_ff != 16'd0) begin
            ticks_dec = ticks_ff - 16'd1;
         end
         if (ticks_dec == 16'd0) begin
            busy_dec = 1'b0;
         end
      end
   end

   // stop after a complete data byte commits it
   assign ram_we = is_stop && (phase_ff == PH_WRPEND);

   always_comb begin
      busy_in  = busy_ff;
      ticks_in = ticks_ff;
      if (accept) begin
         busy_in  = busy_dec;
         ticks_in = ticks_dec;
         if (ram_we) begin
            busy_in  = 1'b1;
            ticks_in = (write_time_ff == 16'd0) ? 16'd1 : write_time_ff;
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && scl_fall) begin
         unique case (phase_ff)
            PH_IDLE:     phase_in = PH_IDLE;
            PH_START:    phase_in = PH_RX_CMD;
            PH_RX_CMD: begin
               if (byte_done) begin
                  phase_in = ((shift_rx & CMD_MASK) == CMD_DEVICE_ID) ? PH_ACK_CMD : PH_IDLE;
               end
            end
            PH_ACK_CMD: begin
               phase_in = ((shift_ff & CMD_READ_BIT) != 8'h00) ? PH_TX_DATA : PH_RX_ADDR;
            end
            PH_RX_ADDR: begin
               if (byte_done) begin
                  phase_in = PH_ACK_ADDR;
               end
            end
            PH_ACK_ADDR: phase_in = PH_RX_DATA;
            PH_RX_DATA: begin
               if (byte_done) begin
                  phase_in = PH_ACK_WR;
               end
            end
            PH_ACK_WR:   phase_in = PH_WRPEND;
            PH_WRPEND:   phase_in = PH_RX_DATA;
            PH_TX_DATA: begin
               if (bitcnt_ff == 4'd0) begin
                  phase_in = PH_ACK_RD;
               end
            end
            PH_ACK_RD:   phase_in = sda ? PH_IDLE : PH_TX_DATA;
            default:     phase_in = phase_ff;
         endcase
      end else if (is_stop) begin
         phase_in = PH_IDLE;
      end else if (is_start) begin
         phase_in = PH_START;
      end
   end

   // shifter, counter, address and sda drive
   always_comb begin
      shift_in  = shift_ff;
      bitcnt_in = bitcnt_ff;
      addr_in   = addr_ff;
      drive_in  = drive_ff;
      if (accept && scl_fall) begin
         unique case (phase_ff)
            PH_IDLE:  drive_in = 1'b1;
            PH_START: drive_in = 1'b1;
            PH_RX_CMD: begin
               shift_in  = shift_rx;
               bitcnt_in = bitcnt_rx;
               if (byte_done && ((shift_rx & CMD_MASK) == CMD_DEVICE_ID)) begin
                  drive_in = 1'b0;
               end
            end
            PH_ACK_CMD: begin
               if ((shift_ff & CMD_READ_BIT) != 8'h00) begin
                  // load the byte and drive its msb
                  shift_in  = mem_byte;
                  bitcnt_in = 4'd7;
                  drive_in  = mem_byte[7];
               end else begin
                  shift_in  = 8'h00;
                  bitcnt_in = 4'd0;
                  drive_in  = 1'b1;
               end
            end
            PH_RX_ADDR: begin
               shift_in  = shift_rx;
               bitcnt_in = bitcnt_rx;
               if (byte_done) begin
                  drive_in = 1'b0;
                  addr_in  = addr_rx;
               end
            end
            PH_ACK_ADDR: begin
               drive_in  = 1'b1;
               shift_in  = 8'h00;
               bitcnt_in = 4'd0;
            end
            PH_RX_DATA: begin
               shift_in  = shift_rx;
               bitcnt_in = bitcnt_rx;
               if (byte_done) begin
                  drive_in = 1'b0;
               end
            end
            PH_ACK_WR: drive_in = 1'b1;
            PH_WRPEND: begin
               // extra data: the new first bit is taken here
               shift_in  = {7'd0, sda};
               bitcnt_in = 4'd1;
            end
            PH_TX_DATA: begin
               if (bitcnt_ff == 4'd0) begin
                  drive_in = 1'b1;
                  addr_in  = addr_next;
               end else begin
                  bitcnt_in = {1'b0, tx_bit};
                  drive_in  = shift_ff[tx_bit];
               end
            end
            PH_ACK_RD: begin
               if (!sda) begin
                  shift_in  = mem_byte;
                  bitcnt_in = 4'd7;
                  drive_in  = mem_byte[7];
               end
            end
            default: drive_in = 1'b1;
         endcase
      end else if (is_start) begin
         shift_in  = 8'h00;
         bitcnt_in = 4'd0;
      end
   end

   assign last_scl_in = accept ? scl : last_scl_ff;
   assign last_sda_in = accept ? sda : last_sda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         shift_ff      <= 8'h00;
         bitcnt_ff     <= 4'd0;
         addr_ff       <= '0;
         drive_ff      <= 1'b1;
         busy_ff       <= 1'b0;
         ticks_ff      <= 16'd0;
         last_scl_ff   <= 1'b1;
         last_sda_ff   <= 1'b1;
         write_time_ff <= WRITE_TIME_RESET;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         shift_ff    <= shift_in;
         bitcnt_ff   <= bitcnt_in;
         addr_ff     <= addr_in;
         drive_ff    <= drive_in;
         busy_ff     <= busy_in;
         ticks_ff    <= ticks_in;
         last_scl_ff <= last_scl_in;
         last_sda_ff <= last_sda_in;
         if (csr_wr_en) begin
            write_time_ff <= csr_wr_data;
         end
         if (ram_we) begin
            valid_ff[addr_ff] <= 1'b1;
         end
         // prefetch tracks the address the next transaction will see
         rd_valid_ff <= valid_ff[addr_in];
         fwd_ff      <= ram_we && (addr_in == addr_ff);
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= shift_ff;
      if (accept) begin
         rsp_data_ff <= {6'd0, busy_in, drive_in};
      end
   end

   eim_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (shift_ff),
      .rd_addr (addr_in),
      .rd_data (ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ design/eim_checker.sv @@
module eim_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data
);

   // a pending response is never dropped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // every accepted transaction gives a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted transaction produced no response");

   // a stalled response blocks new input so it cannot be overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted over a stalled response");

   // with the output register empty the block always takes input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("block stalled with empty output register");

   // no response appears without an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(req_tvalid && req_tready)) |=> !rsp_tvalid)
      else $error("response without transaction");

endmodule

bind i2c_eeprom_slave eim_checker u_eim_checker (.*);
